// ===== sv/tpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tpq_pkg;

   // defaults for the top-level parameters
   localparam int DEPTH_DEF    = 64;
   localparam int KEY_BITS_DEF = 8;

   // fixed field widths of the ports
   localparam int KEY_PORT_BITS  = 8;
   localparam int THR_BITS       = 8;
   localparam int STATUS_BITS    = 2;
   localparam int POSITION_BITS  = 6;
   localparam int REMOVED_BITS   = 8;
   localparam int OCCUPANCY_BITS = 7;

   localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 8'd60;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic cmp_en;   // compare slot against key, capture hit
      logic prio;     // key is at or above the threshold
      logic ins;      // apply an accepted insert
      logic rem;      // apply an accepted remove
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/tpq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpq_cell #(
   parameter int KEY_BITS = 8,
   parameter int CNT_W    = 7,
   parameter int IDX      = 0
) (
   input  wire                       clock,
   input  tpq_pkg::cell_ctrl_type    ctrl,
   input  wire [KEY_BITS-1:0]        key,
   input  wire [CNT_W-1:0]           count_q,
   input  wire [KEY_BITS-1:0]        prev_key,
   input  wire [KEY_BITS-1:0]        next_key,
   input  wire                       pass_in,
   output logic                      pass_out,
   output logic                      first,
   output logic [KEY_BITS-1:0]       slot
);
   import tpq_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [KEY_BITS-1:0] slot_ff, slot_in;
   logic                hit_ff, hit_in;
   logic                occupied;
   logic                at_tail;

   assign occupied = MY_IDX < count_q;
   assign at_tail  = count_q == MY_IDX;

   // capture whether this slot stops a priority placement
   assign hit_in = ctrl.cmp_en ? (occupied && ctrl.prio && (slot_ff <= key)) : hit_ff;

   // an earlier hit means this cell shifts back; the first hit takes the key
   assign pass_out = pass_in | hit_ff;
   assign first    = hit_ff & ~pass_in;
   assign slot     = slot_ff;

   // shift back, load key, or advance toward the head
   always_comb begin
      slot_in = slot_ff;
      if (ctrl.ins) begin
         if (pass_in && (occupied || at_tail)) begin
            slot_in = prev_key;
         end else if (!pass_in && (hit_ff || at_tail)) begin
            slot_in = key;
         end
      end else if (ctrl.rem) begin
         slot_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      hit_ff  <= hit_in;
   end

endmodule
`default_nettype wire

// ===== sv/threshold_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The result strobe rsp_valid is registered: an accepted request passes s1_ff and s2_ff before rsp_valid_ff.
// Busy holds while every cell compares its key (s1); the shift and the result register follow in
//   the apply phase (s2), during which the next operation can already be accepted.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset empties the queue and loads the threshold with 60; slot contents are not cleared
//   and no clearing pass runs, so an operation can start right after reset.
module threshold_priority_queue_top #(
   parameter int DEPTH    = tpq_pkg::DEPTH_DEF,
   parameter int KEY_BITS = tpq_pkg::KEY_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire                                  req_kind,
   input  wire [tpq_pkg::KEY_PORT_BITS-1:0]     req_key,
   output logic                                 rsp_valid,
   output logic [tpq_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [tpq_pkg::POSITION_BITS-1:0]    rsp_position,
   output logic [tpq_pkg::REMOVED_BITS-1:0]     rsp_removed_key,
   output logic [tpq_pkg::OCCUPANCY_BITS-1:0]   rsp_occupancy,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [tpq_pkg::THR_BITS-1:0]          csr_priority_threshold
);
   import tpq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KW    = (KEY_BITS > KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
   localparam int PW    = (CNT_W > POSITION_BITS) ? CNT_W : POSITION_BITS;
   localparam int OW    = (CNT_W > OCCUPANCY_BITS) ? CNT_W : OCCUPANCY_BITS;
   localparam int RW    = (KEY_BITS > REMOVED_BITS) ? KEY_BITS : REMOVED_BITS;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

   // control state
   logic                s1_ff, s1_in;
   logic                s2_ff, s2_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [THR_BITS-1:0] thr_ff, thr_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // transaction payload
   kind_type            kind_ff, kind_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                prio_ff, prio_in;
   status_type          status_ff, status_in;
   logic [POSITION_BITS-1:0]  position_ff, position_in;
   logic [REMOVED_BITS-1:0]   removed_ff, removed_in;
   logic [OCCUPANCY_BITS-1:0] occupancy_ff, occupancy_in;

   logic                accept;
   logic                ins_ok;
   logic                rem_ok;
   logic [KW-1:0]       req_key_wide;
   cell_ctrl_type       ctrl;

   logic [KEY_BITS-1:0] slot_bus [DEPTH];
   logic [KEY_BITS-1:0] prev_bus [DEPTH];
   logic [KEY_BITS-1:0] next_bus [DEPTH];
   logic [DEPTH:0]      pass_bus;
   logic [DEPTH-1:0]    first_vec;
   logic [IDX_W-1:0]    first_idx;
   logic [PW-1:0]       pos_wide;
   logic [OW-1:0]       occ_wide;
   logic [RW-1:0]       removed_wide;

   assign busy      = s1_ff;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign req_key_wide = KW'(req_key);

   // capture the transaction and classify the key against the threshold
   assign kind_in = accept ? kind_type'(req_kind) : kind_ff;
   assign key_in  = accept ? req_key_wide[KEY_BITS-1:0] : key_ff;
   assign prio_in = accept ? (KW'(req_key_wide[KEY_BITS-1:0]) >= KW'(thr_ff)) : prio_ff;

   assign s1_in  = accept;
   assign s2_in  = s1_ff;
   assign thr_in = csr_valid ? csr_priority_threshold : thr_ff;

   assign ins_ok = s2_ff && (kind_ff == KIND_INSERT) && (count_ff != FULL_COUNT);
   assign rem_ok = s2_ff && (kind_ff == KIND_REMOVE) && (count_ff != '0);

   always_comb begin
      ctrl        = '0;
      ctrl.cmp_en = s1_ff;
      ctrl.prio   = prio_ff;
      ctrl.ins    = ins_ok;
      ctrl.rem    = rem_ok;
   end

   // chain the cells: each sees its neighbors' slots and the running hit flag
   assign pass_bus[0] = 1'b0;
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_bus[g] = '0;
      end else begin : g_body
         assign prev_bus[g] = slot_bus[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign next_bus[g] = '0;
      end else begin : g_more
         assign next_bus[g] = slot_bus[g+1];
      end

      tpq_cell #(
         .KEY_BITS (KEY_BITS),
         .CNT_W    (CNT_W),
         .IDX      (g)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .key      (key_ff),
         .count_q  (count_ff),
         .prev_key (prev_bus[g]),
         .next_key (next_bus[g]),
         .pass_in  (pass_bus[g]),
         .pass_out (pass_bus[g+1]),
         .first    (first_vec[g]),
         .slot     (slot_bus[g])
      );
   end

   // encode the one-hot insertion point
   always_comb begin
      first_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_vec[i]) begin
            first_idx = first_idx | IDX_W'(i);
         end
      end
   end

   assign pos_wide     = pass_bus[DEPTH] ? PW'(first_idx) : PW'(count_ff);
   assign occ_wide     = OW'(count_in);
   assign removed_wide = RW'(slot_bus[0]);

   // update occupancy and build the result
   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      position_in  = position_ff;
      removed_in   = removed_ff;
      rsp_valid_in = s2_ff;
      if (ins_ok) begin
         count_in = count_ff + CNT_ONE;
      end else if (rem_ok) begin
         count_in = count_ff - CNT_ONE;
      end
      if (s2_ff) begin
         position_in = '0;
         removed_in  = '0;
         if (kind_ff == KIND_INSERT) begin
            status_in = ins_ok ? STATUS_DONE : STATUS_FULL;
            if (ins_ok) begin
               position_in = pos_wide[POSITION_BITS-1:0];
            end
         end else begin
            status_in = rem_ok ? STATUS_DONE : STATUS_EMPTY;
            if (rem_ok) begin
               removed_in = removed_wide[REMOVED_BITS-1:0];
            end
         end
      end
   end

   assign occupancy_in = s2_ff ? occ_wide[OCCUPANCY_BITS-1:0] : occupancy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         count_ff     <= '0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         count_ff     <= count_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      prio_ff      <= prio_in;
      status_ff    <= status_in;
      position_ff  <= position_in;
      removed_ff   <= removed_in;
      occupancy_ff <= occupancy_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = position_ff;
   assign rsp_removed_key = removed_ff;
   assign rsp_occupancy   = occupancy_ff;

   // check the sequencer and the cell chain
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(s1_ff && s2_ff))
      else $error("compare and apply phases overlap");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("occupancy exceeds depth");

   a_one_point: assert property (@(posedge clock) disable iff (reset)
      s2_ff |-> $onehot0(first_vec))
      else $error("more than one insertion point");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(s2_ff))
      else $error("result without an applied transaction");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ins_ok |=> count_ff == $past(count_ff) + CNT_ONE)
      else $error("insert did not grow the queue");

endmodule
`default_nettype wire

// ===== verif/threshold_priority_queue_top_test.sv =====
`timescale 1ns / 1ps

module threshold_priority_queue_top_test;
   import tpq_pkg::*;

   // one predicted result, field by field at the port widths
   typedef struct {
      status_type                  status;
      logic [POSITION_BITS-1:0]    position;
      logic [REMOVED_BITS-1:0]     removed_key;
      logic [OCCUPANCY_BITS-1:0]   occupancy;
   } queue_rsp_type;

   // shadow copy of the queue: predicts each transaction's result and checks it
   class queue_shadow;
      logic [KEY_PORT_BITS-1:0] slots [DEPTH_DEF];
      int                       occupancy;
      logic [THR_BITS-1:0]      threshold;
      queue_rsp_type            expected_rsps [$];
      int                       mismatches;

      function new();
         occupancy  = 0;
         threshold  = THRESHOLD_RESET;
         mismatches = 0;
      endfunction

      function void set_threshold(logic [THR_BITS-1:0] value);
         threshold = value;
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      // apply an accepted operation and queue its expected result
      function void apply_op(kind_type kind, logic [KEY_PORT_BITS-1:0] key);
         queue_rsp_type rsp;
         int            pos;
         rsp.status      = STATUS_DONE;
         rsp.position    = '0;
         rsp.removed_key = '0;
         if (kind == KIND_INSERT) begin
            if (occupancy >= DEPTH_DEF) begin
               rsp.status = STATUS_FULL;
            end else begin
               pos = occupancy;
               // priority keys go ahead of the first queued key not above them
               if (key >= threshold) begin
                  for (int i = 0; i < occupancy; i++) begin
                     if (slots[i] <= key) begin
                        pos = i;
                        break;
                     end
                  end
                  for (int i = occupancy; i > pos; i--) slots[i] = slots[i-1];
               end
               slots[pos] = key;
               occupancy++;
               rsp.position = pos[POSITION_BITS-1:0];
            end
         end else begin
            if (occupancy == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               // pop the head and advance the rest
               rsp.removed_key = slots[0];
               for (int i = 0; i + 1 < occupancy; i++) slots[i] = slots[i+1];
               occupancy--;
            end
         end
         rsp.occupancy = occupancy[OCCUPANCY_BITS-1:0];
         expected_rsps.push_back(rsp);
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            mismatches++;
         end
      endfunction

      // compare a result with the oldest expectation
      function void check_rsp(logic [STATUS_BITS-1:0] status,
                              logic [POSITION_BITS-1:0] position,
                              logic [REMOVED_BITS-1:0] removed_key,
                              logic [OCCUPANCY_BITS-1:0] occ);
         queue_rsp_type rsp;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual status %0d occupancy %0d",
                     $time, status, occ);
            mismatches++;
            return;
         end
         rsp = expected_rsps.pop_front();
         if ($isunknown({status, position, removed_key, occ})) begin
            $display("%0t: unknown bits in result: expected status %0d, actual %b",
                     $time, rsp.status, status);
            mismatches++;
            return;
         end
         compare_field("status", rsp.status, status);
         compare_field("position", rsp.position, position);
         compare_field("removed_key", rsp.removed_key, removed_key);
         compare_field("occupancy", rsp.occupancy, occ);
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_kind = KIND_INSERT;
   logic [KEY_PORT_BITS-1:0]     req_key = '0;
   logic                         rsp_valid;
   logic [STATUS_BITS-1:0]       rsp_status;
   logic [POSITION_BITS-1:0]     rsp_position;
   logic [REMOVED_BITS-1:0]      rsp_removed_key;
   logic [OCCUPANCY_BITS-1:0]    rsp_occupancy;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [THR_BITS-1:0]          csr_priority_threshold = '0;

   queue_shadow shadow = new();
   bit          gaps_on = 1'b1;

   threshold_priority_queue_top DUT (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_kind               (req_kind),
      .req_key                (req_key),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_position           (rsp_position),
      .rsp_removed_key        (rsp_removed_key),
      .rsp_occupancy          (rsp_occupancy),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_priority_threshold (csr_priority_threshold)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // check every strobed result
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         shadow.check_rsp(rsp_status, rsp_position, rsp_removed_key, rsp_occupancy);
      end
   end

   // sometimes hold off, then present one transaction until it is accepted
   task automatic issue_op(kind_type kind, logic [KEY_PORT_BITS-1:0] key);
      int gap;
      if (gaps_on && $urandom_range(0, 99) < 20) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_kind <= kind;
      req_key  <= key;
      do @(posedge clock); while (busy !== 1'b0);
      shadow.apply_op(kind, key);
   endtask

   // drop start and wait until every expected result has arrived
   task automatic drain_rsps();
      start <= 1'b0;
      do @(posedge clock); while (shadow.pending() > 0);
   endtask

   // write the threshold once the block is idle
   task automatic write_threshold(logic [THR_BITS-1:0] value);
      drain_rsps();
      csr_valid              <= 1'b1;
      csr_priority_threshold <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      shadow.set_threshold(value);
   endtask

   // pick a key, biased toward the threshold, repeats and the extremes
   function automatic logic [KEY_PORT_BITS-1:0] pick_key(logic [KEY_PORT_BITS-1:0] recent);
      int roll;
      int k;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         k = int'(shadow.threshold) + $urandom_range(0, 2) - 1;
         if (k < 0) k = 0;
         if (k > 255) k = 255;
         return k[KEY_PORT_BITS-1:0];
      end else if (roll < 50) begin
         return recent;
      end else if (roll < 60) begin
         return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      return KEY_PORT_BITS'($urandom_range(0, 255));
   endfunction

   initial begin
      logic [KEY_PORT_BITS-1:0] key;
      logic [KEY_PORT_BITS-1:0] recent;
      kind_type                 kind;
      bit                       filling;
      int                       phase;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty remove, both classes at the reset threshold, equal keys
      issue_op(KIND_REMOVE, 8'h00);
      issue_op(KIND_INSERT, 8'd0);
      issue_op(KIND_INSERT, 8'd59);
      issue_op(KIND_INSERT, 8'd60);
      issue_op(KIND_INSERT, 8'd255);
      issue_op(KIND_INSERT, 8'd60);
      issue_op(KIND_INSERT, 8'd100);
      issue_op(KIND_INSERT, 8'd255);
      issue_op(KIND_INSERT, 8'd1);

      // threshold moved while keys are queued: nothing is re-sorted
      write_threshold(8'd255);
      issue_op(KIND_INSERT, 8'd254);
      issue_op(KIND_INSERT, 8'd255);
      write_threshold(8'd0);
      issue_op(KIND_INSERT, 8'd0);

      // drain to empty (the last of these removes already finds it empty), then one more remove on the empty queue
      for (int i = 0; i < 12; i++) issue_op(KIND_REMOVE, (i % 2 == 0) ? 8'hFF : 8'h00);
      issue_op(KIND_REMOVE, 8'hAA);

      // random: alternate filling to full and draining to empty
      filling = 1'b1;
      recent  = 8'd60;
      phase   = 0;
      for (int n = 0; n < 450; n++) begin
         if (n > 0 && n % 75 == 0) begin
            phase++;
            case (phase)
               1: write_threshold(8'd0);
               2: write_threshold(8'd255);
               3: write_threshold(THR_BITS'($urandom_range(1, 254)));
               4: write_threshold(8'd128);
               default: write_threshold(THRESHOLD_RESET);
            endcase
         end
         gaps_on = !(n >= 150 && n < 260);
         if (n == 300) drain_rsps();

         if (filling) kind = ($urandom_range(0, 99) < 85) ? KIND_INSERT : KIND_REMOVE;
         else kind = ($urandom_range(0, 99) < 85) ? KIND_REMOVE : KIND_INSERT;
         key = (kind == KIND_INSERT) ? pick_key(recent) : 8'($urandom_range(0, 255));
         if (kind == KIND_INSERT) recent = key;
         issue_op(kind, key);

         // flip direction at full or empty, after a few rejected transactions, or now and then at random
         if (filling && shadow.occupancy == DEPTH_DEF && $urandom_range(0, 99) < 35)
            filling = 1'b0;
         else if (!filling && shadow.occupancy == 0 && $urandom_range(0, 99) < 35)
            filling = 1'b1;
         else if ($urandom_range(0, 99) < 2)
            filling = !filling;
      end

      drain_rsps();
      repeat (4) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
